[hw/rtl/dbmc_pkg.sv]
// Package: shared types, codes and helpers of the debounced button mode cycler.
`timescale 1ns / 1ps

package dbmc_pkg;

   // Counter width of the steady and hold counters
   localparam int CNT_W = 16;
   // Width used to compare counters against the tick registers
   localparam int CMP_W = (CNT_W > 16) ? CNT_W : 16;

   localparam int DEB_W   = 10;
   localparam int LPT_W   = 16;
   localparam int MODE_W  = 2;
   localparam int FUNC_W  = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [MODE_W-1:0] mode_type;

   // Item kinds
   localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_MODE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_LOCK = 2'd2;

   // Mode codes
   localparam mode_type MODE_OFF      = 2'd0;
   localparam mode_type MODE_SALIDA   = 2'd1;
   localparam mode_type MODE_RETORNO  = 2'd2;
   localparam mode_type MODE_REGISTRO = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESET_MODE = 2'd2;

   // Register reset values
   localparam logic [DEB_W-1:0]  DEBOUNCE_RST   = 10'd50;
   localparam logic [LPT_W-1:0]  LONG_PRESS_RST = 16'd5000;
   localparam mode_type          RESET_MODE_RST = MODE_OFF;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              pin_level;
      mode_type          new_mode;
      logic              lock_value;
   } req_word_type;

   typedef struct packed {
      mode_type mode;
      logic     mode_changed;
      logic     press_rejected;
      logic     long_press;
      logic     locked_now;
   } rsp_word_type;

   typedef struct packed {
      logic [DEB_W-1:0] debounce_ticks;
      logic [LPT_W-1:0] long_press_ticks;
      mode_type         reset_mode;
   } cfg_type;

   function automatic count_type sat_inc(input count_type v);
      count_type r;
      r = (v == '1) ? v : v + count_type'(1);
      return r;
   endfunction

   // Short-press cycle: salida -> retorno -> off -> salida, registro -> salida
   function automatic mode_type next_mode(input mode_type m);
      mode_type r;
      unique case (m)
         MODE_SALIDA:  r = MODE_RETORNO;
         MODE_RETORNO: r = MODE_OFF;
         default:      r = MODE_SALIDA;
      endcase
      return r;
   endfunction

endpackage

[hw/rtl/dbmc_csr.sv]
// Configuration registers of the debounced button mode cycler.
`timescale 1ns / 1ps

module dbmc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wr_en,
   input  logic [dbmc_pkg::CSR_IDX_W-1:0]     wr_index,
   input  logic [dbmc_pkg::CSR_DATA_W-1:0]    wr_data,
   output dbmc_pkg::cfg_type                  cfg
);

   logic [dbmc_pkg::DEB_W-1:0] debounce_ff, debounce_in;
   logic [dbmc_pkg::LPT_W-1:0] long_press_ff, long_press_in;
   dbmc_pkg::mode_type         reset_mode_ff, reset_mode_in;

   always_comb begin
      debounce_in   = debounce_ff;
      long_press_in = long_press_ff;
      reset_mode_in = reset_mode_ff;
      if (reset) begin
         debounce_in   = dbmc_pkg::DEBOUNCE_RST;
         long_press_in = dbmc_pkg::LONG_PRESS_RST;
         reset_mode_in = dbmc_pkg::RESET_MODE_RST;
      end else if (wr_en) begin
         unique case (wr_index)
            dbmc_pkg::CSR_DEBOUNCE:   debounce_in   = wr_data[dbmc_pkg::DEB_W-1:0];
            dbmc_pkg::CSR_LONG_PRESS: long_press_in = wr_data[dbmc_pkg::LPT_W-1:0];
            dbmc_pkg::CSR_RESET_MODE: reset_mode_in = wr_data[dbmc_pkg::MODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      debounce_ff   <= debounce_in;
      long_press_ff <= long_press_in;
      reset_mode_ff <= reset_mode_in;
   end

   // The reset mode is the register's next value, so reset loads the default mode
   assign cfg.debounce_ticks   = debounce_ff;
   assign cfg.long_press_ticks = long_press_ff;
   assign cfg.reset_mode       = reset_mode_in;

endmodule

[hw/rtl/dbmc_core.sv]
// Debounce, hold timing and mode state, updated once per advanced word.
`timescale 1ns / 1ps

module dbmc_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  dbmc_pkg::req_word_type word,
   input  dbmc_pkg::cfg_type      cfg,
   output dbmc_pkg::rsp_word_type result
);

   logic                 prev_ff, prev_in;
   logic                 stable_ff, stable_in;
   dbmc_pkg::count_type  steady_ff, steady_in;
   dbmc_pkg::count_type  hold_ff, hold_in;
   logic                 pressing_ff, pressing_in;
   logic                 fired_ff, fired_in;
   logic                 locked_ff, locked_in;
   dbmc_pkg::mode_type   mode_ff, mode_in;

   logic                 changed, rejected, longp, level_taken;
   dbmc_pkg::count_type  hold_step;

   always_comb begin
      prev_in     = prev_ff;
      stable_in   = stable_ff;
      steady_in   = steady_ff;
      hold_in     = hold_ff;
      pressing_in = pressing_ff;
      fired_in    = fired_ff;
      locked_in   = locked_ff;
      mode_in     = mode_ff;
      changed     = 1'b0;
      rejected    = 1'b0;
      longp       = 1'b0;
      hold_step   = pressing_ff ? dbmc_pkg::sat_inc(hold_ff) : hold_ff;
      level_taken = 1'b0;

      unique case (word.func)
         dbmc_pkg::FUNC_TICK: begin
            hold_in   = hold_step;
            steady_in = (word.pin_level != prev_ff) ? '0 : dbmc_pkg::sat_inc(steady_ff);
            level_taken = (dbmc_pkg::CMP_W'(steady_in) > dbmc_pkg::CMP_W'(cfg.debounce_ticks))
                          && (word.pin_level != stable_ff);
            if (level_taken) begin
               stable_in = word.pin_level;
               if (!word.pin_level) begin
                  hold_in     = '0;
                  pressing_in = 1'b1;
                  fired_in    = 1'b0;
               end else if (pressing_ff) begin
                  if ((dbmc_pkg::CMP_W'(hold_step) < dbmc_pkg::CMP_W'(cfg.long_press_ticks))
                      && !fired_ff) begin
                     if (locked_ff) begin
                        rejected = 1'b1;
                     end else begin
                        mode_in = dbmc_pkg::next_mode(mode_ff);
                        changed = 1'b1;
                     end
                  end
                  pressing_in = 1'b0;
               end
            end
            if (pressing_in && !fired_in
                && (dbmc_pkg::CMP_W'(hold_in) >= dbmc_pkg::CMP_W'(cfg.long_press_ticks))) begin
               fired_in = 1'b1;
               longp    = 1'b1;
            end
            prev_in = word.pin_level;
         end
         dbmc_pkg::FUNC_MODE: begin
            mode_in = word.new_mode;
            changed = 1'b1;
         end
         dbmc_pkg::FUNC_LOCK: begin
            locked_in = word.lock_value;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff     <= 1'b1;
         stable_ff   <= 1'b1;
         steady_ff   <= '0;
         hold_ff     <= '0;
         pressing_ff <= 1'b0;
         fired_ff    <= 1'b0;
         locked_ff   <= 1'b0;
         mode_ff     <= cfg.reset_mode;
      end else if (advance) begin
         prev_ff     <= prev_in;
         stable_ff   <= stable_in;
         steady_ff   <= steady_in;
         hold_ff     <= hold_in;
         pressing_ff <= pressing_in;
         fired_ff    <= fired_in;
         locked_ff   <= locked_in;
         mode_ff     <= mode_in;
      end
   end

   assign result.mode           = mode_in;
   assign result.mode_changed   = changed;
   assign result.press_rejected = rejected;
   assign result.long_press     = longp;
   assign result.locked_now     = locked_in;

endmodule

[hw/rtl/debounced_button_mode_cycler_unit.sv]
// Top level of the debounced button mode cycler: handshakes and word registers.
`timescale 1ns / 1ps

// Debounced button mode cycler.
// Request channel (req_valid, req_stall, req_word): each word is either a
// 1 ms tick with the raw active-low button level, a mode write or a lock
// write. A word is taken at a rising edge with req_valid high and req_stall
// low. Response channel (rsp_valid, rsp_stall, rsp_word): exactly one word
// per request, in order, carrying the mode, the lock flag and the event
// flags (mode changed, press rejected, long press).
// Configuration (csr_valid, csr_ready, csr_index, csr_data): debounce ticks,
// long-press ticks and reset mode; csr_ready is always high. Write only
// while the block is idle.
// A request taken into the input register passes through the state update into
// the response register, which drives rsp_word. Throughput: one word per cycle
// while rsp_stall is low; the state update is a single pass of compares and
// saturating increments between the input and response registers.
// Reset (synchronous, active high): both stages empty, button released,
// counters cleared, unlocked, registers at defaults, mode off.
// When rsp_stall holds the response register, the input register still
// takes one more word; after that req_stall rises until the response moves.
module debounced_button_mode_cycler_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  dbmc_pkg::req_word_type              req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output dbmc_pkg::rsp_word_type              rsp_word,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dbmc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dbmc_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic                   in_valid_ff, in_valid_in;
   dbmc_pkg::req_word_type in_word_ff;
   logic                   out_valid_ff, out_valid_in;
   dbmc_pkg::rsp_word_type out_word_ff;

   logic                   req_take, out_free, advance;
   dbmc_pkg::cfg_type      cfg;
   dbmc_pkg::rsp_word_type result;

   // Configuration is always accepted
   assign csr_ready = 1'b1;

   dbmc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // Response register is free when empty or being drained this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   // Move the held request into the state update and response register
   assign advance   = in_valid_ff && out_free;
   // Hold off the sender only when the input register cannot empty
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   dbmc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .word    (in_word_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: load on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         out_word_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   // A release cannot both change the mode and be rejected
   a_change_xor_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_word.mode_changed && rsp_word.press_rejected))
      else $error("mode change and rejected press on one word");

   // A long press fires only while held, never with a mode change
   a_long_not_change: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_word.long_press && rsp_word.mode_changed))
      else $error("long press together with mode change");

   // Back-pressure only when the input register is full and cannot drain
   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("request stalled without a full pipeline");

   // A stalled response keeps its word
   a_out_held: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> (out_valid_ff && $stable(out_word_ff)))
      else $error("response register changed under stall");

endmodule

[verif/dbmc_mode_checker.sv]
// Checker for the button mode cycler: predicts each response word and compares it.
`timescale 1ns / 1ps

module dbmc_mode_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  dbmc_pkg::req_word_type          req_word,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  dbmc_pkg::rsp_word_type          rsp_word,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [dbmc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dbmc_pkg::CSR_DATA_W-1:0] csr_data,
   output int                              fail_count,
   output int                              pending
);

   logic [dbmc_pkg::DEB_W-1:0] deb_reg;
   logic [dbmc_pkg::LPT_W-1:0] lpt_reg;
   dbmc_pkg::mode_type         rmode_reg;

   logic                last_pin;
   logic                settled_pin;
   dbmc_pkg::count_type steady_ticks;
   dbmc_pkg::count_type held_ticks;
   logic                in_press;
   logic                long_done;
   logic                lock_flag;
   dbmc_pkg::mode_type  cur_mode;

   dbmc_pkg::rsp_word_type expected_words[$];
   dbmc_pkg::rsp_word_type want;
   int                     errs = 0;

   function automatic dbmc_pkg::count_type bump(input dbmc_pkg::count_type v);
      return (v == '1) ? v : v + dbmc_pkg::count_type'(1);
   endfunction

   function automatic dbmc_pkg::mode_type cycle_mode(input dbmc_pkg::mode_type m);
      dbmc_pkg::mode_type n;
      case (m)
         dbmc_pkg::MODE_SALIDA:  n = dbmc_pkg::MODE_RETORNO;
         dbmc_pkg::MODE_RETORNO: n = dbmc_pkg::MODE_OFF;
         default:                n = dbmc_pkg::MODE_SALIDA;
      endcase
      return n;
   endfunction

   // Advance the button state by one request word and build its response.
   task automatic step_button(input dbmc_pkg::req_word_type w,
                              output dbmc_pkg::rsp_word_type r);
      r = '0;
      case (w.func)
         dbmc_pkg::FUNC_TICK: begin
            if (in_press) held_ticks = bump(held_ticks);
            if (w.pin_level != last_pin) steady_ticks = '0;
            else steady_ticks = bump(steady_ticks);
            if (dbmc_pkg::CMP_W'(steady_ticks) > dbmc_pkg::CMP_W'(deb_reg)
                && w.pin_level != settled_pin) begin
               settled_pin = w.pin_level;
               if (!w.pin_level) begin
                  held_ticks = '0;
                  in_press   = 1'b1;
                  long_done  = 1'b0;
               end else if (in_press) begin
                  if (dbmc_pkg::CMP_W'(held_ticks) < dbmc_pkg::CMP_W'(lpt_reg)
                      && !long_done) begin
                     if (lock_flag) begin
                        r.press_rejected = 1'b1;
                     end else begin
                        cur_mode       = cycle_mode(cur_mode);
                        r.mode_changed = 1'b1;
                     end
                  end
                  in_press = 1'b0;
               end
            end
            if (in_press && !long_done
                && dbmc_pkg::CMP_W'(held_ticks) >= dbmc_pkg::CMP_W'(lpt_reg)) begin
               long_done    = 1'b1;
               r.long_press = 1'b1;
            end
            last_pin = w.pin_level;
         end
         dbmc_pkg::FUNC_MODE: begin
            cur_mode       = w.new_mode;
            r.mode_changed = 1'b1;
         end
         dbmc_pkg::FUNC_LOCK: begin
            lock_flag = w.lock_value;
         end
         default: begin
         end
      endcase
      r.mode       = cur_mode;
      r.locked_now = lock_flag;
   endtask

   task automatic check_field(input string name, input logic [1:0] exp_v,
                              input logic [1:0] got_v);
      if (got_v !== exp_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, got_v);
         errs++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         deb_reg      = dbmc_pkg::DEBOUNCE_RST;
         lpt_reg      = dbmc_pkg::LONG_PRESS_RST;
         rmode_reg    = dbmc_pkg::RESET_MODE_RST;
         last_pin     = 1'b1;
         settled_pin  = 1'b1;
         steady_ticks = '0;
         held_ticks   = '0;
         in_press     = 1'b0;
         long_done    = 1'b0;
         lock_flag    = 1'b0;
         cur_mode     = rmode_reg;
         expected_words.delete();
      end else begin
         // retire before predicting: a word never answers in its own cycle
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("response word with none expected");
               errs++;
            end else begin
               want = expected_words.pop_front();
               check_field("mode", want.mode, rsp_word.mode);
               check_field("mode_changed", 2'(want.mode_changed), 2'(rsp_word.mode_changed));
               check_field("press_rejected", 2'(want.press_rejected),
                           2'(rsp_word.press_rejected));
               check_field("long_press", 2'(want.long_press), 2'(rsp_word.long_press));
               check_field("locked_now", 2'(want.locked_now), 2'(rsp_word.locked_now));
            end
         end
         if (req_valid && !req_stall) begin
            step_button(req_word, want);
            expected_words.push_back(want);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               dbmc_pkg::CSR_DEBOUNCE:   deb_reg   = csr_data[dbmc_pkg::DEB_W-1:0];
               dbmc_pkg::CSR_LONG_PRESS: lpt_reg   = csr_data[dbmc_pkg::LPT_W-1:0];
               dbmc_pkg::CSR_RESET_MODE: rmode_reg = csr_data[dbmc_pkg::MODE_W-1:0];
               default: begin
               end
            endcase
         end
      end
      pending    <= expected_words.size();
      fail_count <= errs;
   end

endmodule

[verif/debounced_button_mode_cycler_unit_test.sv]
// Top of the testbench: clock, reset, stimulus, idling and the final verdict.
`timescale 1ns / 1ps

module debounced_button_mode_cycler_unit_test;

   // Codes the package leaves unnamed: the spare item kind and the spare register
   localparam logic [dbmc_pkg::FUNC_W-1:0]    FUNC_SPARE = 2'd3;
   localparam logic [dbmc_pkg::CSR_IDX_W-1:0] CSR_SPARE  = 2'd3;

   logic                            clock;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   dbmc_pkg::req_word_type          req_word  = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   dbmc_pkg::rsp_word_type          rsp_word;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [dbmc_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [dbmc_pkg::CSR_DATA_W-1:0] csr_data  = '0;

   int fail_count;
   int pending;

   // Idle rates in percent; the receiver rate is read by its own process
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   // Current debounce and long-press settings, used to shape the presses
   int cur_deb = 50;
   int cur_lp  = 5000;
   int sent    = 0;

   debounced_button_mode_cycler_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   dbmc_mode_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Receiver: stall at random at the current rate, never during reset
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < rsp_idle_pct);
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #40_000_000;
      $display("debounced_button_mode_cycler_unit_test: FAIL");
      $finish;
   end

   // Random contents in every field; the caller picks the item kind.
   function automatic dbmc_pkg::req_word_type random_word(
      input logic [dbmc_pkg::FUNC_W-1:0] kind);
      dbmc_pkg::req_word_type w;
      w.func       = kind;
      w.pin_level  = 1'($urandom_range(1));
      w.new_mode   = dbmc_pkg::mode_type'($urandom_range(3));
      w.lock_value = 1'($urandom_range(1));
      return w;
   endfunction

   // Offer one word and hold it until taken. Valid stays high on return so
   // that back-to-back words follow without a gap; gaps are inserted up front.
   task automatic put_word(input dbmc_pkg::req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic tick(input logic level);
      dbmc_pkg::req_word_type w;
      w           = random_word(dbmc_pkg::FUNC_TICK);
      w.pin_level = level;
      put_word(w);
   endtask

   task automatic write_mode(input dbmc_pkg::mode_type m);
      dbmc_pkg::req_word_type w;
      w          = random_word(dbmc_pkg::FUNC_MODE);
      w.new_mode = m;
      put_word(w);
   endtask

   task automatic write_lock(input logic v);
      dbmc_pkg::req_word_type w;
      w            = random_word(dbmc_pkg::FUNC_LOCK);
      w.lock_value = v;
      put_word(w);
   endtask

   // Drop valid and hold off until every outstanding response has been taken.
   // The first edge lets the count catch up with the last word accepted.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic set_register(input logic [dbmc_pkg::CSR_IDX_W-1:0] idx,
                               input logic [dbmc_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Write every register with the block idle. Bits above each register's
   // width are randomised to check they are dropped.
   task automatic configure(input int deb, input int lp);
      logic [dbmc_pkg::CSR_DATA_W-1:0] d;
      drain();
      d = dbmc_pkg::CSR_DATA_W'($urandom);
      d[dbmc_pkg::DEB_W-1:0] = dbmc_pkg::DEB_W'(deb);
      set_register(dbmc_pkg::CSR_DEBOUNCE, d);
      set_register(dbmc_pkg::CSR_LONG_PRESS, dbmc_pkg::CSR_DATA_W'(lp));
      set_register(dbmc_pkg::CSR_RESET_MODE, dbmc_pkg::CSR_DATA_W'($urandom));
      set_register(CSR_SPARE, dbmc_pkg::CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
      cur_deb = deb;
      cur_lp  = lp;
   endtask

   // A burst of random ticks: contact bounce around an edge
   task automatic bounce(input int n);
      repeat (n) tick(1'($urandom_range(1)));
   endtask

   // Any non-tick item, dropped into a hold to show it does not advance time
   task automatic stray_write();
      int r;
      r = $urandom_range(2);
      if (r == 0) write_mode(dbmc_pkg::mode_type'($urandom_range(3)));
      else if (r == 1) write_lock(1'($urandom_range(2) == 0));
      else put_word(random_word(FUNC_SPARE));
   endtask

   // One press and release. Mostly long enough to be accepted, with holds
   // either side of the long-press threshold; now and then cut short.
   task automatic press_cycle();
      int hold;
      int rel;
      bounce($urandom_range(3));
      if ($urandom_range(99) < 85) hold = $urandom_range(cur_deb + 2, cur_deb + cur_lp + 5);
      else hold = $urandom_range(cur_deb + 1);
      for (int i = 0; i < hold; i++) begin
         if ($urandom_range(19) == 0) stray_write();
         tick(1'b0);
      end
      bounce($urandom_range(3));
      if ($urandom_range(99) < 85) rel = $urandom_range(cur_deb + 2, cur_deb + 5);
      else rel = $urandom_range(cur_deb + 1);
      repeat (rel) tick(1'b1);
   endtask

   task automatic random_action();
      int r;
      r = $urandom_range(99);
      if (r < 70) press_cycle();
      else if (r < 80) bounce($urandom_range(1, cur_deb + 2));
      else if (r < 88) write_mode(dbmc_pkg::mode_type'($urandom_range(3)));
      else if (r < 94) write_lock(1'($urandom_range(2) == 0));
      else if (r < 97) put_word(random_word(FUNC_SPARE));
      else repeat ($urandom_range(1, 2 * cur_deb + 8)) tick(1'($urandom_range(1)));
   endtask

   // One idling regime, in two halves with a fresh small setting each
   task automatic run_phase(input int send_pct, input int recv_pct, input int items);
      int target;
      send_idle_pct = send_pct;
      rsp_idle_pct <= recv_pct;
      repeat (2) begin
         configure($urandom_range(5), $urandom_range(24));
         target = sent + items / 2;
         while (sent < target) random_action();
      end
   endtask

   initial begin
      int waited;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: spare item kind, every mode code (one twice), lock and unlock
      put_word(random_word(FUNC_SPARE));
      write_mode(dbmc_pkg::MODE_REGISTRO);
      write_mode(dbmc_pkg::MODE_OFF);
      write_mode(dbmc_pkg::MODE_SALIDA);
      write_mode(dbmc_pkg::MODE_RETORNO);
      write_mode(dbmc_pkg::MODE_RETORNO);
      write_lock(1'b1);
      write_lock(1'b0);

      // Zero debounce: accept on the second steady tick; short press toggles
      configure(0, 3);
      tick(1'b0); tick(1'b0); tick(1'b1); tick(1'b1);
      // Locked short press is rejected
      write_lock(1'b1);
      tick(1'b0); tick(1'b0); tick(1'b1); tick(1'b1);
      write_lock(1'b0);
      // Registro goes to salida
      write_mode(dbmc_pkg::MODE_REGISTRO);
      tick(1'b0); tick(1'b0); tick(1'b1); tick(1'b1);
      // Long press with a lock write mid-hold; release must not toggle
      tick(1'b0); tick(1'b0); tick(1'b0); write_lock(1'b0);
      tick(1'b0); tick(1'b0); tick(1'b0); tick(1'b1); tick(1'b1);
      // Single-tick glitch is never accepted
      tick(1'b0); tick(1'b1);

      // Zero long-press: fires on the accepting tick, release never toggles
      configure(0, 0);
      tick(1'b0); tick(1'b0); tick(1'b1); tick(1'b1);

      // Random phases: slow receiver, then slow sender, then no idling
      run_phase(30, 85, 500);
      run_phase(85, 30, 500);
      run_phase(0, 0, 450);

      // Widest debounce and long-press: a short hold is never accepted
      configure(1023, 65535);
      repeat (40) tick(1'b0);
      repeat (20) tick(1'b1);
      // Large long-press: a hold well short of it toggles
      configure(2, 60000);
      repeat (8) tick(1'b0);
      repeat (5) tick(1'b1);
      // Smallest nonzero long-press
      configure(0, 1);
      repeat (3) press_cycle();

      req_valid <= 1'b0;
      waited = 0;
      while (pending != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      // catch any stray word after the last expected one
      repeat (4) @(posedge clock);

      if (fail_count == 0 && pending == 0) begin
         $display("debounced_button_mode_cycler_unit_test: PASS");
      end else begin
         $display("debounced_button_mode_cycler_unit_test: FAIL");
      end
      $finish;
   end

endmodule
